@@ hdl/dertlv_pkg.sv @@
// Shared types, constants and helpers for the DER TLV header parser.
package dertlv_pkg;

  // Width of the tag and length accumulators.
  localparam int FIELD_BITS = 32;
  localparam int OUT_BITS = 32;

  // Identifier and length octet fields.
  localparam logic [7:0] ID_CONSTRUCTED = 8'h20;
  localparam logic [4:0] ID_TAG_ESCAPE = 5'h1F;
  localparam logic [7:0] GROUP_MASK = 8'h7F;
  localparam logic [7:0] LEN_INDEFINITE = 8'h80;
  localparam logic [7:0] OCTET_COUNT_MAX = 8'hFF;

  // Result status codes.
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_END_OF_DATA = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } item_t;

  typedef struct packed {
    logic [1:0]          tag_class;
    logic                is_constructed;
    logic [OUT_BITS-1:0] tag_number;
    logic [OUT_BITS-1:0] content_length;
    logic                indefinite_length;
    logic [7:0]          header_octets;
    logic [1:0]          status;
  } result_t;

  // Zero-extends or truncates an accumulator to the result field width.
  function automatic logic [OUT_BITS-1:0] fit_out(input logic [FIELD_BITS-1:0] acc);
    logic [FIELD_BITS+OUT_BITS-1:0] wide;
    wide = {{OUT_BITS{1'b0}}, acc};
    return wide[OUT_BITS-1:0];
  endfunction

endpackage

@@ hdl/der_tlv_header_parser.sv @@
// Top level of the ASN.1 DER identifier and length header parser.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+----------------------------------------
//   input   | in        | in_valid/in_stall  | data_byte, end_of_data
//   output  | out       | out_valid/out_stall| tag_class, is_constructed, tag_number,
//           |           |                    | content_length, indefinite_length,
//           |           |                    | header_octets, status
//
// One input transfer is taken per cycle while in_stall is low. A byte is held in the
// input register, where the decoder updates the parse state and, if the header
// completes, loads the result register, from which the result transfer is made.
// The decoder update is the only recurrence, which sets the rate.
// A stalled output only holds up a byte that would produce a new result; bytes that
// just extend a header keep flowing. Reset (synchronous, active high) empties both
// registers and returns the parser to the identifier phase.
module der_tlv_header_parser (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      data_byte,
  input  logic                            end_of_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      tag_class,
  output logic                            is_constructed,
  output logic [dertlv_pkg::OUT_BITS-1:0] tag_number,
  output logic [dertlv_pkg::OUT_BITS-1:0] content_length,
  output logic                            indefinite_length,
  output logic [7:0]                      header_octets,
  output logic [1:0]                      status
);
  import dertlv_pkg::*;

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    advance;
  logic    emit;
  logic    room;
  result_t step_result;
  result_t out_result;

  assign in_item.data_byte   = data_byte;
  assign in_item.end_of_data = end_of_data;

  // A held byte moves on unless it completes a header while the result register is full.
  assign advance = held_valid && (!emit || room);

  dertlv_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_item  (held_item),
    .advance    (advance)
  );

  dertlv_decoder u_decoder (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (held_item),
    .emit    (emit),
    .result  (step_result)
  );

  dertlv_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .load        (advance && emit),
    .load_result (step_result),
    .room        (room),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_result  (out_result)
  );

  assign tag_class         = out_result.tag_class;
  assign is_constructed    = out_result.is_constructed;
  assign tag_number        = out_result.tag_number;
  assign content_length    = out_result.content_length;
  assign indefinite_length = out_result.indefinite_length;
  assign header_octets     = out_result.header_octets;
  assign status            = out_result.status;

endmodule

@@ hdl/dertlv_in_reg.sv @@
// Input register stage: captures one header byte transfer per cycle while not stalled.
module dertlv_in_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  dertlv_pkg::item_t   in_item,
  output logic                held_valid,
  output dertlv_pkg::item_t   held_item,
  input  logic                advance
);
  import dertlv_pkg::*;

  logic accept;

  assign in_stall = held_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_item <= in_item;
    end
  end

endmodule

@@ hdl/dertlv_decoder.sv @@
// Header decoder: parse state and the per-byte update of that state.
module dertlv_decoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  dertlv_pkg::item_t   item,
  output logic                emit,
  output dertlv_pkg::result_t result
);
  import dertlv_pkg::*;

  typedef enum logic [1:0] {
    PH_IDENT,
    PH_HIGHTAG,
    PH_LENGTH,
    PH_LONGLEN
  } phase_t;

  phase_t                phase, phase_next;
  logic [1:0]            class_hold, class_hold_next;
  logic                  constructed_hold, constructed_hold_next;
  logic [FIELD_BITS-1:0] tag_accum, tag_accum_next;
  logic [FIELD_BITS-1:0] length_accum, length_accum_next;
  logic [6:0]            length_octets_left, length_octets_left_next;
  logic [7:0]            octet_count, octet_count_next;
  logic                  overflow_flag, overflow_flag_next;

  logic [7:0]            b;
  logic [7:0]            count_inc;
  logic [6:0]            left_dec;

  assign b = item.data_byte;

  always_comb begin
    phase_next              = phase;
    class_hold_next         = class_hold;
    constructed_hold_next   = constructed_hold;
    tag_accum_next          = tag_accum;
    length_accum_next       = length_accum;
    length_octets_left_next = length_octets_left;
    octet_count_next        = octet_count;
    overflow_flag_next      = overflow_flag;
    emit                    = 1'b0;
    count_inc = (octet_count != OCTET_COUNT_MAX) ? octet_count + 8'd1 : octet_count;
    left_dec  = (length_octets_left != 7'd0) ? length_octets_left - 7'd1 : 7'd0;

    result.tag_class         = class_hold;
    result.is_constructed    = constructed_hold;
    result.tag_number        = fit_out(tag_accum);
    result.content_length    = fit_out(length_accum);
    result.indefinite_length = 1'b0;
    result.header_octets     = octet_count;
    result.status            = ST_END_OF_DATA;

    if (item.end_of_data) begin
      emit = (phase != PH_IDENT);
    end else begin
      octet_count_next     = count_inc;
      result.header_octets = count_inc;
      case (phase)
        PH_IDENT: begin
          class_hold_next       = b[7:6];
          constructed_hold_next = |(b & ID_CONSTRUCTED);
          overflow_flag_next    = 1'b0;
          length_accum_next     = '0;
          if (b[4:0] == ID_TAG_ESCAPE) begin
            tag_accum_next = '0;
            phase_next     = PH_HIGHTAG;
          end else begin
            tag_accum_next = FIELD_BITS'(b[4:0]);
            phase_next     = PH_LENGTH;
          end
        end
        PH_HIGHTAG: begin
          if (tag_accum[FIELD_BITS-1:FIELD_BITS-7] != '0) begin
            overflow_flag_next = 1'b1;
          end
          tag_accum_next = {tag_accum[FIELD_BITS-8:0], b[6:0] & GROUP_MASK[6:0]};
          if (!b[7]) begin
            phase_next = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          result.status = overflow_flag ? ST_OVERFLOW : ST_OK;
          if (b == LEN_INDEFINITE) begin
            emit                     = 1'b1;
            result.content_length    = '0;
            result.indefinite_length = 1'b1;
          end else if (!b[7]) begin
            emit                  = 1'b1;
            result.content_length = fit_out(FIELD_BITS'(b));
          end else begin
            length_accum_next       = '0;
            length_octets_left_next = b[6:0];
            phase_next              = PH_LONGLEN;
          end
        end
        PH_LONGLEN: begin
          if (length_accum[FIELD_BITS-1:FIELD_BITS-8] != '0) begin
            overflow_flag_next = 1'b1;
          end
          length_accum_next       = {length_accum[FIELD_BITS-9:0], b};
          length_octets_left_next = left_dec;
          result.content_length   = fit_out(length_accum_next);
          result.status           = overflow_flag_next ? ST_OVERFLOW : ST_OK;
          emit                    = (left_dec == 7'd0);
        end
        default: begin
          phase_next = PH_IDENT;
        end
      endcase
    end

    // Every emitted result returns the parser to its idle state.
    if (emit) begin
      phase_next              = PH_IDENT;
      class_hold_next         = '0;
      constructed_hold_next   = 1'b0;
      tag_accum_next          = '0;
      length_accum_next       = '0;
      length_octets_left_next = '0;
      octet_count_next        = '0;
      overflow_flag_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_IDENT;
      class_hold         <= '0;
      constructed_hold   <= 1'b0;
      tag_accum          <= '0;
      length_accum       <= '0;
      length_octets_left <= '0;
      octet_count        <= '0;
      overflow_flag      <= 1'b0;
    end else if (advance) begin
      phase              <= phase_next;
      class_hold         <= class_hold_next;
      constructed_hold   <= constructed_hold_next;
      tag_accum          <= tag_accum_next;
      length_accum       <= length_accum_next;
      length_octets_left <= length_octets_left_next;
      octet_count        <= octet_count_next;
      overflow_flag      <= overflow_flag_next;
    end
  end

endmodule

@@ hdl/dertlv_out_reg.sv @@
// Result register: holds one decoded header until the consumer takes it.
module dertlv_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  dertlv_pkg::result_t load_result,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output dertlv_pkg::result_t out_result
);
  import dertlv_pkg::*;

  // The register can take a new result when empty or when its content leaves now.
  assign room = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_result <= load_result;
    end
  end

endmodule

@@ hdl/dertlv_checker.sv @@
// Port-level checks for the DER TLV header parser, bound to the top level.
module dertlv_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic        indefinite_length,
  input logic [31:0] content_length,
  input logic [31:0] tag_number,
  input logic [7:0]  header_octets
);
  import dertlv_pkg::*;

  // A stalled result keeps its content.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(tag_number) && $stable(status)
      && $stable(content_length) && $stable(header_octets))
    else $error("result changed while stalled");

  // Only defined status codes leave the block.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == ST_OK || status == ST_END_OF_DATA || status == ST_OVERFLOW)
    else $error("undefined status code");

  // An indefinite length only comes from a finished header and carries no length.
  a_indefinite: assert property (@(posedge clk) disable iff (rst)
    out_valid && indefinite_length |-> content_length == '0 && status != ST_END_OF_DATA)
    else $error("inconsistent indefinite length result");

  // Every result consumed at least one octet; a finished header at least two.
  a_octets: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> header_octets != 8'd0
      && (status == ST_END_OF_DATA || header_octets >= 8'd2))
    else $error("header octet count too small");

endmodule

bind der_tlv_header_parser dertlv_checker u_dertlv_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .status            (status),
  .indefinite_length (indefinite_length),
  .content_length    (content_length),
  .tag_number        (tag_number),
  .header_octets     (header_octets)
);

@@ test/der_header_checker.sv @@
// Decodes DER header octets alongside the parser and checks every result it emits.
`timescale 1ns / 100ps

module der_header_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [7:0]            data_byte,
  input  logic                  end_of_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [1:0]            tag_class,
  input  logic                  is_constructed,
  input  logic [dertlv_pkg::OUT_BITS-1:0] tag_number,
  input  logic [dertlv_pkg::OUT_BITS-1:0] content_length,
  input  logic                  indefinite_length,
  input  logic [7:0]            header_octets,
  input  logic [1:0]            status,
  output int                    pending_results,
  output int                    mismatch_count
);
  import dertlv_pkg::*;

  typedef enum logic [1:0] {
    READ_ID,
    READ_HIGH_TAG,
    READ_LEN,
    READ_LONG_LEN
  } phase_t;

  phase_t                phase;
  logic [1:0]            class_seen;
  logic                  constructed_seen;
  logic [FIELD_BITS-1:0] tag_acc;
  logic [FIELD_BITS-1:0] len_acc;
  logic [6:0]            len_octets_left;
  logic [7:0]            octets_taken;
  logic                  too_wide;
  result_t               expected_headers[$];
  int                    errors = 0;
  int                    expected_count = 0;

  assign pending_results = expected_count;
  assign mismatch_count = errors;

  task automatic clear_parse();
    phase = READ_ID;
    class_seen = '0;
    constructed_seen = 1'b0;
    tag_acc = '0;
    len_acc = '0;
    len_octets_left = '0;
    octets_taken = '0;
    too_wide = 1'b0;
  endtask

  // Queues the header gathered so far and starts over at the identifier.
  task automatic close_header(input logic data_ran_out, input logic indef);
    result_t    r;
    logic [63:0] wide_tag;
    logic [63:0] wide_len;
    wide_tag = 64'(tag_acc);
    wide_len = 64'(len_acc);
    r.tag_class = class_seen;
    r.is_constructed = constructed_seen;
    r.tag_number = wide_tag[OUT_BITS-1:0];
    r.content_length = indef ? '0 : wide_len[OUT_BITS-1:0];
    r.indefinite_length = indef;
    r.header_octets = octets_taken;
    if (data_ran_out) r.status = ST_END_OF_DATA;
    else if (too_wide) r.status = ST_OVERFLOW;
    else r.status = ST_OK;
    expected_headers.push_back(r);
    clear_parse();
  endtask

  task automatic decode_octet(input logic [7:0] b, input logic eod);
    if (eod) begin
      if (phase != READ_ID) close_header(1'b1, 1'b0);
    end else begin
      if (octets_taken != OCTET_COUNT_MAX) octets_taken++;
      case (phase)
        READ_ID: begin
          class_seen = b[7:6];
          constructed_seen = b[5];
          too_wide = 1'b0;
          len_acc = '0;
          if (b[4:0] == ID_TAG_ESCAPE) begin
            tag_acc = '0;
            phase = READ_HIGH_TAG;
          end else begin
            tag_acc = FIELD_BITS'(b[4:0]);
            phase = READ_LEN;
          end
        end
        READ_HIGH_TAG: begin
          if ((tag_acc >> (FIELD_BITS - 7)) != 0) too_wide = 1'b1;
          tag_acc = (tag_acc << 7) | FIELD_BITS'(b[6:0]);
          if (!b[7]) phase = READ_LEN;
        end
        READ_LEN: begin
          if (b == LEN_INDEFINITE) begin
            close_header(1'b0, 1'b1);
          end else if (b < LEN_INDEFINITE) begin
            len_acc = FIELD_BITS'(b);
            close_header(1'b0, 1'b0);
          end else begin
            len_acc = '0;
            len_octets_left = b[6:0];
            phase = READ_LONG_LEN;
          end
        end
        default: begin
          if ((len_acc >> (FIELD_BITS - 8)) != 0) too_wide = 1'b1;
          len_acc = (len_acc << 8) | FIELD_BITS'(b);
          if (len_octets_left != 7'd0) len_octets_left--;
          if (len_octets_left == 7'd0) close_header(1'b0, 1'b0);
        end
      endcase
    end
  endtask

  task automatic report_mismatch(input string msg);
    errors++;
    $display("%0t ns: header mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      clear_parse();
      expected_headers.delete();
    end else begin
      if (in_valid && !in_stall) decode_octet(data_byte, end_of_data);
      if (out_valid && !out_stall) begin
        if (expected_headers.size() == 0) begin
          report_mismatch("result transfer with no header expected");
        end else begin
          want = expected_headers.pop_front();
          check_field("tag_class", 64'(tag_class), 64'(want.tag_class));
          check_field("is_constructed", 64'(is_constructed), 64'(want.is_constructed));
          check_field("tag_number", 64'(tag_number), 64'(want.tag_number));
          check_field("content_length", 64'(content_length), 64'(want.content_length));
          check_field("indefinite_length", 64'(indefinite_length),
                      64'(want.indefinite_length));
          check_field("header_octets", 64'(header_octets), 64'(want.header_octets));
          check_field("status", 64'(status), 64'(want.status));
        end
      end
    end
    expected_count <= expected_headers.size();
  end

endmodule

@@ test/testbench.sv @@
// Stimulus and verdict for the DER identifier and length header parser.
`timescale 1ns / 100ps

module testbench;
  import dertlv_pkg::*;

  // Cycles without any transfer on either channel before the run is declared hung.
  localparam int IDLE_LIMIT = 2000;
  // The parser answers through its input and result registers; this leaves ample margin.
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_OCTETS = 520;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic end_of_data = 1'b0;
  logic out_stall = 1'b0;

  logic in_stall;
  logic out_valid;
  logic [1:0] tag_class;
  logic is_constructed;
  logic [OUT_BITS-1:0] tag_number;
  logic [OUT_BITS-1:0] content_length;
  logic indefinite_length;
  logic [7:0] header_octets;
  logic [1:0] status;

  int results_pending;
  int mismatches;

  // Percentages of cycles in which the sender holds back or the receiver stalls.
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int octets_sent = 0;

  // Octets of the header currently being built, sent front to back.
  logic [7:0] header_octs[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  der_tlv_header_parser u_top (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .data_byte         (data_byte),
    .end_of_data       (end_of_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .tag_class         (tag_class),
    .is_constructed    (is_constructed),
    .tag_number        (tag_number),
    .content_length    (content_length),
    .indefinite_length (indefinite_length),
    .header_octets     (header_octets),
    .status            (status)
  );

  der_header_checker u_check (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .data_byte         (data_byte),
    .end_of_data       (end_of_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .tag_class         (tag_class),
    .is_constructed    (is_constructed),
    .tag_number        (tag_number),
    .content_length    (content_length),
    .indefinite_length (indefinite_length),
    .header_octets     (header_octets),
    .status            (status),
    .pending_results   (results_pending),
    .mismatch_count    (mismatches)
  );

  // The receiver stalls independently each cycle, at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: the run is hung if neither channel completes a transfer for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("** der_tlv_header_parser: FAILED **");
    $finish;
  end

  // Offers one octet, or an end-of-data marker, and returns once the transfer is taken.
  // Any idle gap is decided before valid rises, so valid never follows the stall.
  task automatic send(input logic [7:0] b, input logic eod);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    end_of_data <= eod;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (!eod) octets_sent++;
  endtask

  task automatic send_queued();
    foreach (header_octs[i]) send(header_octs[i], 1'b0);
  endtask

  // End of data with a random, ignored data byte.
  task automatic send_end();
    send(8'($urandom_range(255)), 1'b1);
  endtask

  // Holds the sender off until every result owed so far has arrived. The checker
  // updates its count just after the edge, so it is read at the falling edge.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (results_pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Builds a well-formed header with random content. Most tags and lengths fit in
  // 32 bits; a few are long enough to overflow, and some carry leading zero groups
  // or leading zero length octets, which must be decoded by value.
  task automatic build_header();
    logic [7:0] ident;
    logic [6:0] grp;
    logic [6:0] count;
    int groups;
    int len_octs;
    int pick;
    header_octs.delete();
    ident = 8'($urandom_range(255));
    if ($urandom_range(99) < 40) ident[4:0] = ID_TAG_ESCAPE;
    header_octs.push_back(ident);
    if (ident[4:0] == ID_TAG_ESCAPE) begin
      groups = ($urandom_range(9) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 4);
      for (int i = 0; i < groups; i++) begin
        grp = 7'($urandom_range(127));
        if (i == 0 && $urandom_range(7) == 0) grp = '0;
        header_octs.push_back({(i < groups - 1), grp});
      end
    end
    pick = $urandom_range(99);
    if (pick < 40) begin
      grp = 7'($urandom_range(127));
      header_octs.push_back({1'b0, grp});
    end else if (pick < 55) begin
      header_octs.push_back(LEN_INDEFINITE);
    end else begin
      len_octs = (pick < 95) ? $urandom_range(1, 4) : $urandom_range(5, 8);
      count = 7'(len_octs);
      header_octs.push_back({1'b1, count});
      for (int i = 0; i < len_octs; i++) begin
        if (i == 0 && $urandom_range(7) == 0) header_octs.push_back(8'h00);
        else header_octs.push_back(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin : stimulus
    int base;
    int pick;
    int cut;
    int noise_len;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed headers, with light idling on both sides.
    sender_idle_pct = 17;
    stall_pct = 17;
    // All-zero identifier and a zero short length.
    header_octs = '{8'h00, 8'h00};
    send_queued();
    // Private, constructed, high-tag form with a tag that just fills 32 bits, then
    // an indefinite length: no overflow is flagged.
    header_octs = '{8'hFF, 8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h80};
    send_queued();
    // High-tag form with a leading zero group, then the largest four-octet length.
    header_octs = '{8'h9F, 8'h80, 8'h01, 8'h84, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_queued();
    // Application tag with the largest short length.
    header_octs = '{8'h41, 8'h7F};
    send_queued();
    // Five length octets: the length overflows.
    header_octs = '{8'h22, 8'h85, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00};
    send_queued();
    // End of data between headers produces nothing; inside a header it ends it.
    send_end();
    send(8'h1F, 1'b0);
    send(8'h81, 1'b0);
    send_end();
    send(8'h04, 1'b0);
    send(8'h82, 1'b0);
    send(8'h12, 1'b0);
    send_end();

    // Length octet 0xFF: the long form with 127 length octets.
    header_octs = '{8'h02, 8'hFF};
    repeat (127) header_octs.push_back(8'($urandom_range(255)));
    send_queued();
    // Hundreds of zero tag groups push the octet count past its saturation point.
    header_octs = '{8'h1F};
    repeat (300) header_octs.push_back(8'h80);
    header_octs.push_back(8'h05);
    header_octs.push_back(8'h00);
    send_queued();

    // Random part in four phases of pacing; the sender drains all results between
    // phases, so the pipeline is also seen restarting from empty.
    base = octets_sent;
    for (int ph = 0; ph < 4; ph++) begin
      wait_for_results();
      case (ph)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 54; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 54; end
        default: begin sender_idle_pct = 17; stall_pct = 17; end
      endcase
      while (octets_sent - base < RANDOM_OCTETS * (ph + 1) / 4) begin
        pick = $urandom_range(99);
        if (pick < 85) begin
          // A well-formed header, now and then cut short by end of data.
          build_header();
          cut = header_octs.size();
          if ($urandom_range(9) == 0) cut = $urandom_range(1, header_octs.size() - 1);
          for (int i = 0; i < cut; i++) send(header_octs[i], 1'b0);
          if (cut < header_octs.size()) send_end();
        end else if (pick < 93) begin
          // Raw noise, closed by end of data so the next header starts cleanly.
          noise_len = $urandom_range(1, 6);
          repeat (noise_len) send(8'($urandom_range(255)), 1'b0);
          send_end();
        end else begin
          send_end();
        end
      end
    end

    // Drain: all results in, then a few more cycles to catch anything extra.
    wait_for_results();
    stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_pending == 0)
      $display("** der_tlv_header_parser: PASSED **");
    else
      $display("** der_tlv_header_parser: FAILED **");
    $finish;
  end

endmodule
